// File: rtl/drbrlt_pkg.sv
// Shared types and constants for the DRAM bank row latency tracker.
// No dependencies; used by the controller, datapath and top level.
package drbrlt_pkg;

    localparam int NUM_BANKS    = 8;
    localparam int BANK_BITS    = $clog2(NUM_BANKS);
    localparam int BURST_CYCLES = 4;
    localparam int BUS_BITS     = 32;
    localparam int ADDR_BITS    = 32;
    localparam int LEN_BITS     = 16;

    localparam int BANK_LSB     = 12;
    localparam int ROW_LSB      = 15;
    localparam int ROW_BITS     = ADDR_BITS - ROW_LSB;

    localparam int BURST_BYTES  = 2 * BURST_CYCLES * BUS_BITS / 8;
    localparam int BURST_SHIFT  = $clog2(BURST_BYTES);
    localparam int WBEAT_BYTES  = 8;
    localparam int WBEAT_SHIFT  = $clog2(WBEAT_BYTES);

    localparam int LIMIT_BITS   = 33;
    localparam int DELAY_BITS   = 6;
    localparam int CFG_BITS     = LIMIT_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int CYCLES_BITS  = 14;

    localparam logic [CYCLES_BITS-1:0] CYCLES_MAX = '1;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET = LIMIT_BITS'(65536);
    localparam logic [DELAY_BITS-1:0]  DELAY_RESET = DELAY_BITS'(16);

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CMD_ERR  = 2'd1,
        ST_ADDR_ERR = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MEM_LIMIT = 2'd0,
        CFG_CAS       = 2'd1,
        CFG_ACTIVATE  = 2'd2,
        CFG_PRECHARGE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic load_in;
        logic load_out;
    } dp_cmd_t;

endpackage

// File: rtl/drbrlt_ctrl.sv
// Controller state machine for the latency tracker.
// Depends on drbrlt_pkg; drives load commands into drbrlt_dpath.
module drbrlt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output drbrlt_pkg::dp_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load_in  = 1'b0;
        cmd.load_out = 1'b0;
        state_next   = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next   = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/drbrlt_dpath.sv
// Datapath: config registers, bank open-row table and latency arithmetic.
// Depends on drbrlt_pkg; sequenced by drbrlt_ctrl.
module drbrlt_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  drbrlt_pkg::dp_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [drbrlt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [drbrlt_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic [1:0]                          action,
    input  logic [drbrlt_pkg::ADDR_BITS-1:0]    address,
    input  logic [drbrlt_pkg::LEN_BITS-1:0]     length,
    output logic [drbrlt_pkg::CYCLES_BITS-1:0]  cycles,
    output logic [1:0]                          status
);

    logic [drbrlt_pkg::LIMIT_BITS-1:0] mem_limit_reg;
    logic [drbrlt_pkg::DELAY_BITS-1:0] cas_reg, act_reg, pre_reg;

    logic [1:0]                        action_reg;
    logic [drbrlt_pkg::ADDR_BITS-1:0]  address_reg;
    logic [drbrlt_pkg::LEN_BITS-1:0]   length_reg;

    logic [drbrlt_pkg::NUM_BANKS-1:0]  bank_open_reg;
    logic [drbrlt_pkg::ROW_BITS-1:0]   bank_row_reg [drbrlt_pkg::NUM_BANKS];

    logic [drbrlt_pkg::CYCLES_BITS-1:0] cycles_reg, cycles_next;
    logic [1:0]                         status_reg, status_next;

    logic [drbrlt_pkg::BANK_BITS-1:0]  bank;
    logic [drbrlt_pkg::ROW_BITS-1:0]   row;
    logic                              addr_err;
    logic                              do_update;
    logic [drbrlt_pkg::LEN_BITS:0]     rd_round, wr_round;
    logic [drbrlt_pkg::CYCLES_BITS:0]  rd_sum, wr_cycles;
    logic [drbrlt_pkg::CYCLES_BITS:0]  row_penalty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_limit_reg <= drbrlt_pkg::LIMIT_RESET;
            cas_reg       <= drbrlt_pkg::DELAY_RESET;
            act_reg       <= drbrlt_pkg::DELAY_RESET;
            pre_reg       <= drbrlt_pkg::DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (drbrlt_pkg::cfg_idx_t'(cfg_index))
                drbrlt_pkg::CFG_MEM_LIMIT: mem_limit_reg <= cfg_data;
                drbrlt_pkg::CFG_CAS:
                    cas_reg <= cfg_data[drbrlt_pkg::DELAY_BITS-1:0];
                drbrlt_pkg::CFG_ACTIVATE:
                    act_reg <= cfg_data[drbrlt_pkg::DELAY_BITS-1:0];
                drbrlt_pkg::CFG_PRECHARGE:
                    pre_reg <= cfg_data[drbrlt_pkg::DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg  <= action;
            address_reg <= address;
            length_reg  <= length;
        end
    end

    assign bank = address_reg[drbrlt_pkg::BANK_LSB +: drbrlt_pkg::BANK_BITS];
    assign row  = address_reg[drbrlt_pkg::ROW_LSB +: drbrlt_pkg::ROW_BITS];
    assign addr_err = {1'b0, address_reg} >= mem_limit_reg;

    always_comb
    begin
        rd_round = {1'b0, length_reg} + (drbrlt_pkg::LEN_BITS+1)'(drbrlt_pkg::BURST_BYTES - 1);
        wr_round = {1'b0, length_reg} + (drbrlt_pkg::LEN_BITS+1)'(drbrlt_pkg::WBEAT_BYTES - 1);
        wr_cycles = (drbrlt_pkg::CYCLES_BITS+1)'(wr_round >> drbrlt_pkg::WBEAT_SHIFT);

        if (!bank_open_reg[bank])
            row_penalty = (drbrlt_pkg::CYCLES_BITS+1)'(act_reg);
        else if (bank_row_reg[bank] != row)
            row_penalty = (drbrlt_pkg::CYCLES_BITS+1)'(act_reg)
                        + (drbrlt_pkg::CYCLES_BITS+1)'(pre_reg);
        else
            row_penalty = '0;

        rd_sum = (drbrlt_pkg::CYCLES_BITS+1)'(
                     (rd_round >> drbrlt_pkg::BURST_SHIFT) * drbrlt_pkg::BURST_CYCLES)
               + (drbrlt_pkg::CYCLES_BITS+1)'(cas_reg)
               + row_penalty;

        do_update   = 1'b0;
        cycles_next = '0;
        status_next = drbrlt_pkg::ST_OK;
        if (addr_err)
        begin
            status_next = drbrlt_pkg::ST_ADDR_ERR;
        end
        else
        begin
            case (action_reg)
                drbrlt_pkg::ACT_READ:
                begin
                    do_update   = 1'b1;
                    cycles_next = rd_sum[drbrlt_pkg::CYCLES_BITS] ? drbrlt_pkg::CYCLES_MAX
                                : rd_sum[drbrlt_pkg::CYCLES_BITS-1:0];
                end
                drbrlt_pkg::ACT_WRITE:
                begin
                    do_update   = 1'b1;
                    cycles_next = wr_cycles[drbrlt_pkg::CYCLES_BITS] ? drbrlt_pkg::CYCLES_MAX
                                : wr_cycles[drbrlt_pkg::CYCLES_BITS-1:0];
                end
                default:
                begin
                    status_next = drbrlt_pkg::ST_CMD_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bank_open_reg <= '0;
        else if (cmd.load_out && do_update)
            bank_open_reg[bank] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out && do_update)
            bank_row_reg[bank] <= row;
        if (cmd.load_out)
        begin
            cycles_reg <= cycles_next;
            status_reg <= status_next;
        end
    end

    assign cycles = cycles_reg;
    assign status = status_reg;

endmodule

// File: rtl/dram_bank_row_latency_tracker_unit.sv
// Top level of the DRAM bank row latency tracker.
// Depends on drbrlt_pkg, drbrlt_ctrl and drbrlt_dpath.
//
//   Channel   Handshake             Beat contents
//   input     in_valid / in_ready   action, address, length
//   output    out_valid / out_ready cycles, status
//   config    cfg_we                cfg_index, cfg_data
//
// Each beat is captured in the idle state; the compute state then looks up the
// bank table, computes the latency and updates the table and the result register.
// A new input beat is taken only in the idle state, once the last result is loaded.
// A stalled result holds in the output register; the next request is captured
// meanwhile and waits in the compute state until the result is taken.
// Reset clears the control state and the bank open bits and loads the config defaults.
module dram_bank_row_latency_tracker_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          action,
    input  logic [drbrlt_pkg::ADDR_BITS-1:0]    address,
    input  logic [drbrlt_pkg::LEN_BITS-1:0]     length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [drbrlt_pkg::CYCLES_BITS-1:0]  cycles,
    output logic [1:0]                          status,
    input  logic                                cfg_we,
    input  logic [drbrlt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [drbrlt_pkg::CFG_BITS-1:0]     cfg_data
);

    drbrlt_pkg::dp_cmd_t cmd;

    drbrlt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    drbrlt_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .action    (action),
        .address   (address),
        .length    (length),
        .cycles    (cycles),
        .status    (status)
    );

endmodule
